// File: sv/color_blob_extent_tracker_defines.svh
// ----------------------------------------------------------------------------
// Color blob extent tracker - assertion macros
// Concurrent assertion wrappers, clocked on i_clk and disabled while the
// synchronous reset i_rst_n is low. Define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef COLOR_BLOB_EXTENT_TRACKER_DEFINES_SVH
`define COLOR_BLOB_EXTENT_TRACKER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Property that must hold at every clock edge outside reset.
`define CBET_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Condition at one edge implies consequence at the next edge.
`define CBET_ASSERT_NEXT(label, cond, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (cons)) \
        else $error(msg);

`else

`define CBET_ASSERT(label, prop, msg)
`define CBET_ASSERT_NEXT(label, cond, cons, msg)

`endif

`endif

// File: sv/cbet_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Color blob extent tracker - package
// Request and result types, register indexes, class codes and the constants
// shared by the tracker.
// ----------------------------------------------------------------------------
package cbet_pkg;

    localparam int LEVEL_W  = 8;
    localparam int ROW_W    = 10;
    localparam int COL_W    = 10;
    localparam int RADIUS_W = 14;
    localparam int CFG_IDX_W = 3;

    // Frame bounds; pixels at or beyond these are ignored by the tracking
    localparam int MAX_ROWS = 1024;
    localparam int MAX_COLS = 1024;
    localparam int BOUND_W  = 13;

    // span * scale fits in PROD_W bits; floor(x / 10) = (x * DIV10_MULT) >> DIV10_SHIFT
    // holds for every x below 2**18
    localparam int PROD_W      = ROW_W + LEVEL_W;
    localparam int DIV10_SHIFT = 21;
    localparam logic [PROD_W-1:0] DIV10_MULT = 18'd209716;
    localparam int QUOT_W      = 2 * PROD_W - DIV10_SHIFT;
    localparam logic [QUOT_W-1:0] RADIUS_MAX = 15'd16383;

    localparam int NUM_CLASSES = 3;

    // Register reset values
    localparam logic [LEVEL_W-1:0] HIGH_LEVEL_RST   = 8'd100;
    localparam logic [LEVEL_W-1:0] LOW_LEVEL_RST    = 8'd50;
    localparam logic [LEVEL_W-1:0] YELLOW_BLUE_RST  = 8'd20;
    localparam logic [LEVEL_W-1:0] RED_SCALE_RST    = 8'd50;
    localparam logic [LEVEL_W-1:0] GREEN_SCALE_RST  = 8'd30;
    localparam logic [LEVEL_W-1:0] YELLOW_SCALE_RST = 8'd12;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HIGH_LEVEL   = 3'd0,
        REG_LOW_LEVEL    = 3'd1,
        REG_YELLOW_BLUE  = 3'd2,
        REG_RED_SCALE    = 3'd3,
        REG_GREEN_SCALE  = 3'd4,
        REG_YELLOW_SCALE = 3'd5
    } t_cfg_reg;

    typedef enum logic [1:0] {
        CLS_RED    = 2'd0,
        CLS_GREEN  = 2'd1,
        CLS_YELLOW = 2'd2
    } t_color_class;

    typedef struct packed {
        logic [LEVEL_W-1:0] blue_level;
        logic [LEVEL_W-1:0] green_level;
        logic [LEVEL_W-1:0] red_level;
        logic [ROW_W-1:0]   pixel_row;
        logic [COL_W-1:0]   pixel_col;
        logic               frame_end;
    } t_pixel;

    typedef struct packed {
        logic [1:0]          color_class;
        logic                class_found;
        logic [ROW_W-1:0]    center_row;
        logic [COL_W-1:0]    center_col;
        logic [RADIUS_W-1:0] radius;
        logic                final_result;
    } t_result;

    // Per-class tracking record
    typedef struct packed {
        logic             found;
        logic [ROW_W-1:0] first_row;
        logic [COL_W-1:0] first_col;
        logic [ROW_W-1:0] last_row;
    } t_track;

    // First result stage: geometry done, radius still in tenths
    typedef struct packed {
        t_color_class     cls;
        logic             found;
        logic [ROW_W-1:0] center_row;
        logic [COL_W-1:0] center_col;
        logic [PROD_W-1:0] prod;
    } t_stage;

endpackage

// File: sv/color_blob_extent_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Color blob extent tracker
// Classes raster-order pixels as red, green or yellow, tracks the first hit
// and last row of each class, and reports center and radius at frame end.
// ----------------------------------------------------------------------------
// The block takes one pixel per clock. A pixel is registered, then classed
// and folded into the per-class tracking registers in the following cycle.
// The pixel marked frame_end copies the updated tracking into a result
// buffer and clears the tracking, so the next frame starts at once. The
// three results (red, green, yellow) leave the buffer one per cycle, unless
// the output stalls, through two result stages (multiply by scale, then
// divide by ten by reciprocal multiply), each ending in a register. Input
// stalls only when a frame_end pixel arrives while the buffer still holds
// results of the previous frame, which happens with frames shorter than
// three pixels or with a stalled output.
`include "color_blob_extent_tracker_defines.svh"

module color_blob_extent_tracker
    import cbet_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [LEVEL_W-1:0]   i_cfg_data,
    input  logic                 i_in_valid,
    input  t_pixel               i_in_data,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    output t_result              o_out_data,
    input  logic                 i_out_stall
);

    // Configuration registers
    logic [LEVEL_W-1:0] r_high_level;
    logic [LEVEL_W-1:0] r_low_level;
    logic [LEVEL_W-1:0] r_yellow_blue;
    logic [LEVEL_W-1:0] r_red_scale;
    logic [LEVEL_W-1:0] r_green_scale;
    logic [LEVEL_W-1:0] r_yellow_scale;

    // Pixel stage
    logic   r_px_v;
    t_pixel r_px;
    logic   a_go;
    logic   buf_free;
    logic   in_frame;
    logic   hit [NUM_CLASSES];

    // Tracking and result buffer
    t_track r_trk [NUM_CLASSES];
    t_track n_trk [NUM_CLASSES];
    t_track r_buf [NUM_CLASSES];
    logic   r_buf_v;
    logic   n_buf_v;
    t_color_class r_cls;
    t_color_class n_cls;

    // Result pipeline
    logic   adv;
    t_track sel_trk;
    logic [LEVEL_W-1:0] sel_scale;
    logic [ROW_W:0]     row_sum;
    logic [ROW_W-1:0]   crow;
    logic [ROW_W-1:0]   span;
    t_stage  r_e1;
    t_stage  n_e1;
    logic    r_e1_v;
    logic [2*PROD_W-1:0] quot_full;
    logic [QUOT_W-1:0]   quot;
    t_result r_out;
    t_result n_out;
    logic    r_out_v;

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high_level   <= HIGH_LEVEL_RST;
            r_low_level    <= LOW_LEVEL_RST;
            r_yellow_blue  <= YELLOW_BLUE_RST;
            r_red_scale    <= RED_SCALE_RST;
            r_green_scale  <= GREEN_SCALE_RST;
            r_yellow_scale <= YELLOW_SCALE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_HIGH_LEVEL:   r_high_level   <= i_cfg_data;
                REG_LOW_LEVEL:    r_low_level    <= i_cfg_data;
                REG_YELLOW_BLUE:  r_yellow_blue  <= i_cfg_data;
                REG_RED_SCALE:    r_red_scale    <= i_cfg_data;
                REG_GREEN_SCALE:  r_green_scale  <= i_cfg_data;
                REG_YELLOW_SCALE: r_yellow_scale <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake and pipeline control
    // ------------------------------------------------------------------
    assign adv      = !r_out_v || !i_out_stall;
    assign buf_free = !r_buf_v || (adv && (r_cls == CLS_YELLOW));
    assign a_go     = r_px_v && (!r_px.frame_end || buf_free);
    assign o_in_stall = r_px_v && !a_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_px_v <= 1'b0;
        end else if (i_in_valid && !o_in_stall) begin
            r_px_v <= 1'b1;
        end else if (a_go) begin
            r_px_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_px <= i_in_data;
        end
    end

    // ------------------------------------------------------------------
    // Classification and tracking update
    // ------------------------------------------------------------------
    assign in_frame = (BOUND_W'(r_px.pixel_row) < BOUND_W'(MAX_ROWS))
                   && (BOUND_W'(r_px.pixel_col) < BOUND_W'(MAX_COLS));

    always_comb begin
        hit[CLS_RED]    = (r_px.red_level >= r_high_level)
                       && (r_px.blue_level < r_low_level)
                       && (r_px.green_level < r_low_level);
        hit[CLS_GREEN]  = !hit[CLS_RED]
                       && (r_px.green_level >= r_high_level)
                       && (r_px.blue_level < r_low_level)
                       && (r_px.red_level < r_low_level);
        hit[CLS_YELLOW] = !hit[CLS_RED] && !hit[CLS_GREEN]
                       && (r_px.blue_level < r_yellow_blue)
                       && (r_px.green_level >= r_high_level)
                       && (r_px.red_level >= r_high_level);
    end

    always_comb begin
        for (int c = 0; c < NUM_CLASSES; c++) begin
            n_trk[c] = r_trk[c];
            if (in_frame && hit[c]) begin
                if (!r_trk[c].found) begin
                    n_trk[c].found     = 1'b1;
                    n_trk[c].first_row = r_px.pixel_row;
                    n_trk[c].first_col = r_px.pixel_col;
                    n_trk[c].last_row  = r_px.pixel_row;
                end else if (r_px.pixel_row > r_trk[c].first_row) begin
                    n_trk[c].last_row  = r_px.pixel_row;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_CLASSES; c++) begin
                r_trk[c] <= '0;
            end
        end else if (a_go) begin
            for (int c = 0; c < NUM_CLASSES; c++) begin
                r_trk[c] <= r_px.frame_end ? '0 : n_trk[c];
            end
        end
    end

    // Snapshot the updated tracking on the frame's last pixel
    always_ff @(posedge i_clk) begin
        if (a_go && r_px.frame_end) begin
            for (int c = 0; c < NUM_CLASSES; c++) begin
                r_buf[c] <= n_trk[c];
            end
        end
    end

    // ------------------------------------------------------------------
    // Result sequencing: red, green, yellow
    // ------------------------------------------------------------------
    always_comb begin
        n_cls   = r_cls;
        n_buf_v = r_buf_v;
        if (adv && r_buf_v) begin
            unique case (r_cls)
                CLS_RED:    n_cls = CLS_GREEN;
                CLS_GREEN:  n_cls = CLS_YELLOW;
                CLS_YELLOW: begin
                    n_cls   = CLS_RED;
                    n_buf_v = 1'b0;
                end
                default: begin
                    n_cls   = CLS_RED;
                    n_buf_v = 1'b0;
                end
            endcase
        end
        if (a_go && r_px.frame_end) begin
            n_buf_v = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cls   <= CLS_RED;
            r_buf_v <= 1'b0;
        end else begin
            r_cls   <= n_cls;
            r_buf_v <= n_buf_v;
        end
    end

    // ------------------------------------------------------------------
    // Result stage 1: center and scaled half extent
    // ------------------------------------------------------------------
    always_comb begin
        unique case (r_cls)
            CLS_RED: begin
                sel_trk   = r_buf[CLS_RED];
                sel_scale = r_red_scale;
            end
            CLS_GREEN: begin
                sel_trk   = r_buf[CLS_GREEN];
                sel_scale = r_green_scale;
            end
            CLS_YELLOW: begin
                sel_trk   = r_buf[CLS_YELLOW];
                sel_scale = r_yellow_scale;
            end
            default: begin
                sel_trk   = '0;
                sel_scale = '0;
            end
        endcase
    end

    // last_row never falls below first_row, so span cannot wrap
    assign row_sum = {1'b0, sel_trk.first_row} + {1'b0, sel_trk.last_row};
    assign crow    = row_sum[ROW_W:1];
    assign span    = sel_trk.last_row - crow;

    always_comb begin
        n_e1.cls        = r_cls;
        n_e1.found      = sel_trk.found;
        n_e1.center_row = crow;
        n_e1.center_col = sel_trk.first_col;
        n_e1.prod       = PROD_W'(span) * PROD_W'(sel_scale);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e1_v <= 1'b0;
        end else if (adv) begin
            r_e1_v <= r_buf_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_e1 <= n_e1;
        end
    end

    // ------------------------------------------------------------------
    // Result stage 2: divide by ten, saturate, register the result
    // ------------------------------------------------------------------
    assign quot_full = (2*PROD_W)'(r_e1.prod) * (2*PROD_W)'(DIV10_MULT);
    assign quot      = QUOT_W'(quot_full >> DIV10_SHIFT);

    always_comb begin
        n_out.color_class  = r_e1.cls;
        n_out.class_found  = r_e1.found;
        n_out.center_row   = r_e1.center_row;
        n_out.center_col   = r_e1.center_col;
        n_out.radius       = (quot > RADIUS_MAX) ? RADIUS_MAX[RADIUS_W-1:0]
                                                 : quot[RADIUS_W-1:0];
        n_out.final_result = (r_e1.cls == CLS_YELLOW);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (adv) begin
            r_out_v <= r_e1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `CBET_ASSERT(a_not_found_zero,
        !(r_out_v && !r_out.class_found) || (r_out.center_row == '0
            && r_out.center_col == '0 && r_out.radius == '0),
        "class not found but result fields nonzero")
    `CBET_ASSERT(a_radius_bound,
        !r_out_v || (r_out.radius <= 14'd13056),
        "radius beyond half extent times largest scale")
    `CBET_ASSERT(a_stall_cause,
        !o_in_stall || (r_px_v && r_px.frame_end && r_buf_v),
        "input stalled without a pending frame end")
    `CBET_ASSERT_NEXT(a_frame_clears,
        a_go && r_px.frame_end,
        !r_trk[CLS_RED].found && !r_trk[CLS_GREEN].found && !r_trk[CLS_YELLOW].found,
        "tracking not cleared after frame end")
    `CBET_ASSERT(a_seq_idle,
        r_buf_v || (r_cls == CLS_RED),
        "result sequence left mid-frame with empty buffer")

endmodule
